>>> sv/tgvk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgvk_pkg;

   localparam int VOLUME_MAX_DEFAULT         = 100;
   localparam int REPEAT_INTERVAL_US_DEFAULT = 200000;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_SINGLE     = 3'd1;
   localparam logic [2:0] EV_DOUBLE     = 3'd2;
   localparam logic [2:0] EV_LONG_START = 3'd3;
   localparam logic [2:0] EV_LONG_END   = 3'd4;

   localparam logic [2:0] REG_DEFAULT_TAP_MAX      = 3'd0;
   localparam logic [2:0] REG_DEFAULT_CLICK_WINDOW = 3'd1;
   localparam logic [2:0] REG_DEFAULT_LONG_PRESS   = 3'd2;
   localparam logic [2:0] REG_KEY_TAP_MAX          = 3'd3;
   localparam logic [2:0] REG_KEY_CLICK_WINDOW     = 3'd4;
   localparam logic [2:0] REG_SIDE_LONG_PRESS      = 3'd5;
   localparam logic [2:0] REG_CENTER_LONG_PRESS    = 3'd6;
   localparam logic [2:0] REG_CODEC_PRESENT        = 3'd7;

   typedef struct packed {
      logic [3:0]  touch_count;
      logic [11:0] touch_x;
      logic [11:0] touch_y;
      logic [31:0] time_us;
      logic [6:0]  current_volume;
      logic        device_starting;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [11:0] event_x;
      logic [11:0] event_y;
      logic        toggle_chat;
      logic        volume_write;
      logic [6:0]  volume_value;
   } rsp_type;

   typedef struct packed {
      logic [23:0] default_tap_max_us;
      logic [23:0] default_click_window_us;
      logic [23:0] default_long_press_us;
      logic [23:0] key_tap_max_us;
      logic [23:0] key_click_window_us;
      logic [23:0] side_key_long_press_us;
      logic [23:0] center_key_long_press_us;
      logic        codec_present;
   } cfg_type;

   typedef struct packed {
      logic        touching;
      logic [31:0] press_start_time;
      logic [31:0] release_time;
      logic [1:0]  click_tally;
      logic        long_press_seen;
      logic        repeat_active;
      logic        repeat_down;
      logic [31:0] repeat_time;
   } state_type;

endpackage

`default_nettype wire

>>> sv/tgvk_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tgvk_step #(
   parameter int VOLUME_MAX         = tgvk_pkg::VOLUME_MAX_DEFAULT,
   parameter int REPEAT_INTERVAL_US = tgvk_pkg::REPEAT_INTERVAL_US_DEFAULT
) (
   input  tgvk_pkg::req_type   req,
   input  tgvk_pkg::cfg_type   cfg,
   input  tgvk_pkg::state_type st,
   output tgvk_pkg::state_type st_in,
   output tgvk_pkg::rsp_type   rsp
);
   import tgvk_pkg::*;

   localparam logic [11:0] KEY_Y      = 12'd600;
   localparam logic [11:0] KEY_UP_X   = 12'd20;
   localparam logic [11:0] KEY_MID_X  = 12'd40;
   localparam logic [11:0] KEY_DOWN_X = 12'd60;
   localparam logic [3:0]  CLICK_STEP  = 4'd10;
   localparam logic [3:0]  REPEAT_STEP = 4'd5;
   localparam logic [7:0]  VMAX = 8'(VOLUME_MAX);
   localparam logic [31:0] REPEAT_US = 32'(REPEAT_INTERVAL_US);

   function automatic logic [7:0] vol_step(input logic [7:0] v, input logic up,
                                           input logic [3:0] step);
      logic [8:0] sum;
      logic [8:0] res;
      sum = {1'b0, v} + {5'd0, step};
      if (up) begin
         res = sum;
      end else if (v < {4'd0, step}) begin
         res = 9'd0;
      end else begin
         res = {1'b0, v} - {5'd0, step};
      end
      if (res > {1'b0, VMAX}) begin
         res = {1'b0, VMAX};
      end
      return res[7:0];
   endfunction

   logic        at_key;
   logic [31:0] tap_max;
   logic [31:0] window;
   logic [31:0] long_us;
   logic [31:0] held;
   logic [31:0] quiet;
   logic [31:0] since_repeat;
   logic [2:0]  kind;
   logic        tog;
   logic        wr;
   logic [7:0]  wval;
   logic [7:0]  vol;
   logic [7:0]  nv;

   assign at_key = (req.touch_y == KEY_Y) && ((req.touch_x == KEY_UP_X) ||
                   (req.touch_x == KEY_MID_X) || (req.touch_x == KEY_DOWN_X));
   assign held  = req.time_us - st.press_start_time;
   assign quiet = req.time_us - st.release_time;

   always_comb begin
      if (at_key) begin
         tap_max = {8'd0, cfg.key_tap_max_us};
         window  = {8'd0, cfg.key_click_window_us};
         long_us = (req.touch_x == KEY_MID_X) ? {8'd0, cfg.center_key_long_press_us}
                                              : {8'd0, cfg.side_key_long_press_us};
      end else begin
         tap_max = {8'd0, cfg.default_tap_max_us};
         window  = {8'd0, cfg.default_click_window_us};
         long_us = {8'd0, cfg.default_long_press_us};
      end
   end

   always_comb begin
      st_in = st;
      kind  = EV_NONE;
      tog   = 1'b0;
      wr    = 1'b0;
      wval  = 8'd0;
      vol   = {1'b0, req.current_volume};

      if (req.touch_count != 4'd0 && !st.touching) begin
         st_in.touching         = 1'b1;
         st_in.press_start_time = req.time_us;
         st_in.long_press_seen  = 1'b0;
      end else if (req.touch_count != 4'd0) begin
         if (!st.long_press_seen && held >= long_us) begin
            kind                  = EV_LONG_START;
            st_in.long_press_seen = 1'b1;
         end
      end else if (st.touching) begin
         st_in.touching     = 1'b0;
         st_in.release_time = req.time_us;
         if (st.long_press_seen) begin
            kind = EV_LONG_END;
         end else if (held <= tap_max && st.click_tally != 2'd3) begin
            st_in.click_tally = st.click_tally + 2'd1;
         end
      end else if (st.click_tally != 2'd0 && quiet >= window) begin
         kind              = (st.click_tally == 2'd2) ? EV_DOUBLE : EV_SINGLE;
         st_in.click_tally = 2'd0;
      end

      if (kind != EV_NONE && at_key) begin
         case (kind)
            EV_SINGLE: begin
               if (req.touch_x == KEY_MID_X) begin
                  tog = !req.device_starting;
               end else if (cfg.codec_present) begin
                  vol  = vol_step(vol, req.touch_x == KEY_UP_X, CLICK_STEP);
                  wr   = 1'b1;
                  wval = vol;
               end
            end
            EV_LONG_START: begin
               if (req.touch_x != KEY_MID_X) begin
                  st_in.repeat_active = 1'b1;
                  st_in.repeat_down   = (req.touch_x == KEY_DOWN_X);
                  st_in.repeat_time   = req.time_us;
               end
            end
            EV_LONG_END: begin
               if (req.touch_x != KEY_MID_X) begin
                  st_in.repeat_active = 1'b0;
                  st_in.repeat_down   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      since_repeat = req.time_us - st_in.repeat_time;
      nv = vol_step(vol, !st_in.repeat_down, REPEAT_STEP);
      if (st_in.repeat_active && cfg.codec_present && since_repeat >= REPEAT_US) begin
         if (nv != vol) begin
            wr                = 1'b1;
            wval              = nv;
            st_in.repeat_time = req.time_us;
         end else begin
            st_in.repeat_active = 1'b0;
            st_in.repeat_down   = 1'b0;
         end
      end

      rsp.event_kind   = kind;
      rsp.event_x      = (kind != EV_NONE) ? req.touch_x : 12'd0;
      rsp.event_y      = (kind != EV_NONE) ? req.touch_y : 12'd0;
      rsp.toggle_chat  = tog;
      rsp.volume_write = wr;
      rsp.volume_value = wr ? wval[6:0] : 7'd0;
   end

endmodule

`default_nettype wire

>>> sv/touch_gesture_volume_keys.sv
`timescale 1ns / 1ps
`default_nettype none
// Two register stages: the input register takes an accepted request, and the output register drives rsp_valid.
// Throughput: one transaction per cycle while rsp_stall is low; the gesture step is a single
// compare/add pass between the input register and the result register.
// Reset: synchronous, active high; clears valids and gesture state, loads register defaults.
module touch_gesture_volume_keys #(
   parameter int VOLUME_MAX         = tgvk_pkg::VOLUME_MAX_DEFAULT,
   parameter int REPEAT_INTERVAL_US = tgvk_pkg::REPEAT_INTERVAL_US_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tgvk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tgvk_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import tgvk_pkg::*;

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;
   logic      advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   tgvk_step #(
      .VOLUME_MAX         (VOLUME_MAX),
      .REPEAT_INTERVAL_US (REPEAT_INTERVAL_US)
   ) u_step (
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .st    (state_ff),
      .st_in (state_in),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_tap_max_us       <= 24'd120000;
         cfg_ff.default_click_window_us  <= 24'd240000;
         cfg_ff.default_long_press_us    <= 24'd4000000;
         cfg_ff.key_tap_max_us           <= 24'd200000;
         cfg_ff.key_click_window_us      <= 24'd240000;
         cfg_ff.side_key_long_press_us   <= 24'd2000000;
         cfg_ff.center_key_long_press_us <= 24'd4000000;
         cfg_ff.codec_present            <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEFAULT_TAP_MAX:      cfg_ff.default_tap_max_us       <= csr_wdata;
            REG_DEFAULT_CLICK_WINDOW: cfg_ff.default_click_window_us  <= csr_wdata;
            REG_DEFAULT_LONG_PRESS:   cfg_ff.default_long_press_us    <= csr_wdata;
            REG_KEY_TAP_MAX:          cfg_ff.key_tap_max_us           <= csr_wdata;
            REG_KEY_CLICK_WINDOW:     cfg_ff.key_click_window_us      <= csr_wdata;
            REG_SIDE_LONG_PRESS:      cfg_ff.side_key_long_press_us   <= csr_wdata;
            REG_CENTER_LONG_PRESS:    cfg_ff.center_key_long_press_us <= csr_wdata;
            REG_CODEC_PRESENT:        cfg_ff.codec_present            <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tgvk_pkg::*;

   localparam logic [11:0] KEY_Y      = 12'd600;
   localparam logic [11:0] KEY_UP_X   = 12'd20;
   localparam logic [11:0] KEY_MID_X  = 12'd40;
   localparam logic [11:0] KEY_DOWN_X = 12'd60;
   localparam int          CLICK_STEP  = 10;
   localparam int          REPEAT_STEP = 5;
   localparam int          LEVEL_MAX   = VOLUME_MAX_DEFAULT;
   localparam logic [31:0] REPEAT_US   = REPEAT_INTERVAL_US_DEFAULT;
   localparam int          PHASE_ITEMS = 75;
   localparam int          WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // gesture tracker shadow
   cfg_type     thresholds;
   logic        touch_down;
   logic [31:0] press_time;
   logic [31:0] lift_time;
   logic [1:0]  tap_tally;
   logic        long_held;
   logic        repeat_on;
   logic        repeat_dir_down;
   logic [31:0] repeat_mark;

   rsp_type     pending_outcomes[$];
   rsp_type     oldest;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   int          sent_count = 0;
   bit          steady = 1'b0;
   logic [31:0] stamp_us = '0;
   logic [6:0]  level_now = 7'd50;
   logic [11:0] gest_x, gest_y;

   touch_gesture_volume_keys uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic cfg_type default_settings();
      cfg_type c;
      c.default_tap_max_us       = 24'd120000;
      c.default_click_window_us  = 24'd240000;
      c.default_long_press_us    = 24'd4000000;
      c.key_tap_max_us           = 24'd200000;
      c.key_click_window_us      = 24'd240000;
      c.side_key_long_press_us   = 24'd2000000;
      c.center_key_long_press_us = 24'd4000000;
      c.codec_present            = 1'b1;
      return c;
   endfunction

   function automatic logic is_key(input logic [11:0] x, input logic [11:0] y);
      return (y == KEY_Y) && (x == KEY_UP_X || x == KEY_MID_X || x == KEY_DOWN_X);
   endfunction

   function automatic void pick_limits(input logic [11:0] x, input logic [11:0] y,
                                       output logic [31:0] tap, output logic [31:0] win,
                                       output logic [31:0] hold);
      if (is_key(x, y)) begin
         tap  = {8'd0, thresholds.key_tap_max_us};
         win  = {8'd0, thresholds.key_click_window_us};
         hold = (x == KEY_MID_X) ? {8'd0, thresholds.center_key_long_press_us}
                                 : {8'd0, thresholds.side_key_long_press_us};
      end else begin
         tap  = {8'd0, thresholds.default_tap_max_us};
         win  = {8'd0, thresholds.default_click_window_us};
         hold = {8'd0, thresholds.default_long_press_us};
      end
   endfunction

   function automatic int clamp_level(input int v);
      if (v < 0) return 0;
      if (v > LEVEL_MAX) return LEVEL_MAX;
      return v;
   endfunction

   function automatic rsp_type gesture_outcome(input req_type s);
      rsp_type     r;
      logic        key;
      logic [31:0] tap, win, hold, span;
      logic [2:0]  kind;
      int          level, stepped;
      r = '0;
      kind = EV_NONE;
      key = is_key(s.touch_x, s.touch_y);
      pick_limits(s.touch_x, s.touch_y, tap, win, hold);
      if (s.touch_count != 0 && !touch_down) begin
         touch_down = 1'b1;
         press_time = s.time_us;
         long_held  = 1'b0;
      end else if (s.touch_count != 0) begin
         span = s.time_us - press_time;
         if (!long_held && span >= hold) begin
            kind = EV_LONG_START;
            long_held = 1'b1;
         end
      end else if (touch_down) begin
         span = s.time_us - press_time;
         touch_down = 1'b0;
         lift_time  = s.time_us;
         if (long_held) begin
            kind = EV_LONG_END;
         end else if (span <= tap && tap_tally != 2'd3) begin
            tap_tally = tap_tally + 2'd1;
         end
      end else begin
         span = s.time_us - lift_time;
         if (tap_tally != 0 && span >= win) begin
            kind = (tap_tally == 2'd2) ? EV_DOUBLE : EV_SINGLE;
            tap_tally = 2'd0;
         end
      end

      level = int'(s.current_volume);
      if (kind != EV_NONE && key) begin
         case (kind)
            EV_SINGLE: begin
               if (s.touch_x == KEY_MID_X) begin
                  if (!s.device_starting) r.toggle_chat = 1'b1;
               end else if (thresholds.codec_present) begin
                  level = clamp_level(level + ((s.touch_x == KEY_UP_X) ? CLICK_STEP
                                                                        : -CLICK_STEP));
                  r.volume_write = 1'b1;
                  r.volume_value = 7'(level);
               end
            end
            EV_LONG_START: begin
               if (s.touch_x != KEY_MID_X) begin
                  repeat_on       = 1'b1;
                  repeat_dir_down = (s.touch_x == KEY_DOWN_X);
                  repeat_mark     = s.time_us;
               end
            end
            EV_LONG_END: begin
               if (s.touch_x != KEY_MID_X) begin
                  repeat_on       = 1'b0;
                  repeat_dir_down = 1'b0;
               end
            end
            default: ;
         endcase
      end

      span = s.time_us - repeat_mark;
      if (repeat_on && thresholds.codec_present && span >= REPEAT_US) begin
         stepped = clamp_level(level + (repeat_dir_down ? -REPEAT_STEP : REPEAT_STEP));
         if (stepped != level) begin
            r.volume_write = 1'b1;
            r.volume_value = 7'(stepped);
            repeat_mark = s.time_us;
         end else begin
            repeat_on       = 1'b0;
            repeat_dir_down = 1'b0;
         end
      end

      r.event_kind = kind;
      r.event_x = (kind != EV_NONE) ? s.touch_x : '0;
      r.event_y = (kind != EV_NONE) ? s.touch_y : '0;
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] pick_near(input logic [31:0] limit);
      case ($urandom_range(0, 9))
         0: return limit;
         1: return limit + 1;
         2: return (limit == 0) ? 32'd0 : limit - 1;
         3: return $urandom_range(0, 2 * limit + 1);
         default: return $urandom_range(0, limit);
      endcase
   endfunction

   function automatic logic [23:0] rand_thr();
      case ($urandom_range(0, 9))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(1, 500000));
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on %s: got %0d, expected %0d", field, got, want);
   endtask

   task automatic send_sample(input req_type s);
      rsp_type outcome;
      int      n;
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome = gesture_outcome(s);
      pending_outcomes.push_back(outcome);
      sent_count++;
      if (outcome.volume_write) level_now = outcome.volume_value;
      n = steady ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic touch_sample(input logic [3:0] cnt, input logic [11:0] x,
                               input logic [11:0] y, input logic [31:0] delta,
                               input logic [6:0] vol, input logic starting);
      req_type s;
      stamp_us = stamp_us + delta;
      s.touch_count     = cnt;
      s.touch_x         = x;
      s.touch_y         = y;
      s.time_us         = stamp_us;
      s.current_volume  = vol;
      s.device_starting = starting;
      send_sample(s);
   endtask

   task automatic gesture_sample(input logic [3:0] cnt, input logic [31:0] delta);
      logic [11:0] x, y;
      logic [6:0]  vol;
      x = gest_x;
      y = gest_y;
      if ($urandom_range(0, 9) == 0) begin
         x = 12'($urandom);
         y = 12'($urandom);
      end
      vol = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127)) : level_now;
      touch_sample(cnt, x, y, delta, vol, ($urandom_range(0, 3) == 0));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      logic [23:0] word [8];
      drain_results();
      word[REG_DEFAULT_TAP_MAX]      = c.default_tap_max_us;
      word[REG_DEFAULT_CLICK_WINDOW] = c.default_click_window_us;
      word[REG_DEFAULT_LONG_PRESS]   = c.default_long_press_us;
      word[REG_KEY_TAP_MAX]          = c.key_tap_max_us;
      word[REG_KEY_CLICK_WINDOW]     = c.key_click_window_us;
      word[REG_SIDE_LONG_PRESS]      = c.side_key_long_press_us;
      word[REG_CENTER_LONG_PRESS]    = c.center_key_long_press_us;
      word[REG_CODEC_PRESENT]        = {23'($urandom), c.codec_present};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= word[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      thresholds = c;
   endtask

   task automatic random_gesture();
      logic [31:0] tap, win, hold, dur, part;
      int          n, sel;
      sel = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
         0: gest_x = KEY_UP_X;
         1: gest_x = KEY_MID_X;
         default: gest_x = KEY_DOWN_X;
      endcase
      gest_y = KEY_Y;
      if (sel == 6) gest_y = 12'($urandom);
      else if (sel == 7) gest_x = 12'($urandom);
      else if (sel > 7) begin
         gest_x = 12'($urandom);
         gest_y = 12'($urandom);
      end
      if ($urandom_range(0, 4) == 0) level_now = 7'($urandom_range(0, LEVEL_MAX));
      pick_limits(gest_x, gest_y, tap, win, hold);
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 1) == 1) gesture_sample(4'd0, $urandom_range(0, win));
            gesture_sample(4'($urandom_range(1, 15)), $urandom_range(0, 2000));
            dur = pick_near(tap);
            if ($urandom_range(0, 4) == 0) begin
               part = $urandom_range(0, dur);
               gesture_sample(4'($urandom_range(1, 15)), part);
               dur = dur - part;
            end
            gesture_sample(4'd0, dur);
         end
         part = $urandom_range(0, win);
         gesture_sample(4'd0, part);
         gesture_sample(4'd0, win - part + $urandom_range(0, 3));
      end else if (sel < 8) begin
         gesture_sample(4'($urandom_range(1, 15)), $urandom_range(0, 2000));
         part = $urandom_range(0, hold);
         gesture_sample(4'($urandom_range(1, 15)), part);
         gesture_sample(4'($urandom_range(1, 15)), hold - part + $urandom_range(0, 2));
         n = $urandom_range(0, 24);
         for (int i = 0; i < n; i++) gesture_sample(4'($urandom_range(1, 15)), pick_near(REPEAT_US));
         gesture_sample(4'd0, $urandom_range(0, 5000));
      end else begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            touch_sample(($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(1, 15)),
                         12'($urandom), 12'($urandom),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300000),
                         7'($urandom_range(0, 127)), 1'($urandom));
      end
   endtask

   task automatic random_phase(input int items);
      int first;
      first = sent_count;
      steady = ($urandom_range(0, 3) == 0);
      while (sent_count - first < items) random_gesture();
      steady = 1'b0;
   endtask

   task automatic test_directed();
      stamp_us = 32'd1000;
      // center tap while starting: toggle held back; then a center tap after starting toggles
      touch_sample(4'd1, KEY_MID_X, KEY_Y, 0, 7'd50, 1'b1);
      touch_sample(4'd0, KEY_MID_X, KEY_Y, 100000, 7'd50, 1'b1);
      touch_sample(4'd0, KEY_MID_X, KEY_Y, 240000, 7'd50, 1'b1);
      touch_sample(4'd1, KEY_MID_X, KEY_Y, 5000, 7'd50, 1'b0);
      touch_sample(4'd0, KEY_MID_X, KEY_Y, 100000, 7'd50, 1'b0);
      touch_sample(4'd0, KEY_MID_X, KEY_Y, 240000, 7'd50, 1'b0);
      // step up into the top clamp, down into the bottom clamp
      touch_sample(4'd15, KEY_UP_X, KEY_Y, 5000, 7'd95, 1'b0);
      touch_sample(4'd0, KEY_UP_X, KEY_Y, 200000, 7'd95, 1'b0);
      touch_sample(4'd0, KEY_UP_X, KEY_Y, 240000, 7'd95, 1'b0);
      touch_sample(4'd1, KEY_DOWN_X, KEY_Y, 5000, 7'd3, 1'b0);
      touch_sample(4'd0, KEY_DOWN_X, KEY_Y, 50000, 7'd3, 1'b0);
      touch_sample(4'd0, KEY_DOWN_X, KEY_Y, 300000, 7'd3, 1'b0);
      // double tap
      touch_sample(4'd2, KEY_DOWN_X, KEY_Y, 5000, 7'd50, 1'b0);
      touch_sample(4'd0, KEY_DOWN_X, KEY_Y, 10000, 7'd50, 1'b0);
      touch_sample(4'd1, KEY_DOWN_X, KEY_Y, 50000, 7'd50, 1'b0);
      touch_sample(4'd0, KEY_DOWN_X, KEY_Y, 10000, 7'd50, 1'b0);
      touch_sample(4'd0, KEY_DOWN_X, KEY_Y, 240000, 7'd50, 1'b0);
      // triple tap across the timestamp wrap folds into a single
      stamp_us = 32'hFFFF_FFFF - 32'd2500;
      for (int i = 0; i < 3; i++) begin
         touch_sample(4'd1, 12'hFFF, 12'hFFF, 1000, 7'd127, 1'b0);
         touch_sample(4'd0, 12'hFFF, 12'hFFF, 1000, 7'd127, 1'b0);
      end
      touch_sample(4'd0, 12'hFFF, 12'hFFF, 240000, 7'd127, 1'b0);
      // long press with auto-repeat
      touch_sample(4'd1, KEY_UP_X, KEY_Y, 5000, 7'd40, 1'b0);
      touch_sample(4'd1, KEY_UP_X, KEY_Y, 2000000, 7'd40, 1'b0);
      touch_sample(4'd1, KEY_UP_X, KEY_Y, 200000, 7'd40, 1'b0);
      touch_sample(4'd1, KEY_UP_X, KEY_Y, 200000, 7'd45, 1'b0);
      touch_sample(4'd0, KEY_UP_X, KEY_Y, 1000, 7'd50, 1'b0);
   endtask

   task automatic test_extreme_settings();
      cfg_type c;
      c = '0;
      c.codec_present = 1'b1;
      load_settings(c);
      random_phase(PHASE_ITEMS);
      c = '1;
      load_settings(c);
      random_phase(PHASE_ITEMS);
      c = default_settings();
      c.codec_present = 1'b0;
      load_settings(c);
      random_phase(PHASE_ITEMS);
      c = '0;
      load_settings(c);
      random_phase(PHASE_ITEMS);
   endtask

   task automatic test_random_settings();
      cfg_type c;
      repeat (3) begin
         c.default_tap_max_us       = rand_thr();
         c.default_click_window_us  = rand_thr();
         c.default_long_press_us    = rand_thr();
         c.key_tap_max_us           = rand_thr();
         c.key_click_window_us      = rand_thr();
         c.side_key_long_press_us   = rand_thr();
         c.center_key_long_press_us = rand_thr();
         c.codec_present            = ($urandom_range(0, 3) != 0);
         load_settings(c);
         random_phase(PHASE_ITEMS);
      end
   endtask

   task automatic test_default_settings();
      load_settings(default_settings());
      random_phase(PHASE_ITEMS / 2);
      // hold off until the block has caught up, then resume
      drain_results();
      random_phase(PHASE_ITEMS / 2);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(rsp_data.event_kind),
                               32'(EV_NONE));
            end else begin
               oldest = pending_outcomes.pop_front();
               if (rsp_data.event_kind !== oldest.event_kind)
                  report_mismatch("event_kind", 32'(rsp_data.event_kind),
                                  32'(oldest.event_kind));
               if (rsp_data.event_x !== oldest.event_x)
                  report_mismatch("event_x", 32'(rsp_data.event_x), 32'(oldest.event_x));
               if (rsp_data.event_y !== oldest.event_y)
                  report_mismatch("event_y", 32'(rsp_data.event_y), 32'(oldest.event_y));
               if (rsp_data.toggle_chat !== oldest.toggle_chat)
                  report_mismatch("toggle_chat", 32'(rsp_data.toggle_chat),
                                  32'(oldest.toggle_chat));
               if (rsp_data.volume_write !== oldest.volume_write)
                  report_mismatch("volume_write", 32'(rsp_data.volume_write),
                                  32'(oldest.volume_write));
               if (rsp_data.volume_value !== oldest.volume_value)
                  report_mismatch("volume_value", 32'(rsp_data.volume_value),
                                  32'(oldest.volume_value));
            end
         end
      end
      if (steady) stall_left = 0;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = steady ? 0 : gap_len();
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      thresholds      = default_settings();
      touch_down      = 1'b0;
      press_time      = '0;
      lift_time       = '0;
      tap_tally       = '0;
      long_held       = 1'b0;
      repeat_on       = 1'b0;
      repeat_dir_down = 1'b0;
      repeat_mark     = '0;
      test_directed();
      test_extreme_settings();
      test_random_settings();
      test_default_settings();
      drain_results();
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
sv/tgvk_pkg.sv
sv/tgvk_step.sv
sv/touch_gesture_volume_keys.sv
tb/sv/testbench.sv
